FILE: sv/multi_queue_packet_ring_buffer_core_macros.svh
// Assertion macros shared by the ring buffer RTL.
`ifndef MULTI_QUEUE_PACKET_RING_BUFFER_CORE_MACROS_SVH
`define MULTI_QUEUE_PACKET_RING_BUFFER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MQRB_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MQRB_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MQRB_ASSERT_IMP(name, ck, rs, ante, cons)
`define MQRB_ASSERT_NXT(name, ck, rs, ante, cons)
`endif
`endif

FILE: sv/mqrb_pkg.sv
// Shared codes and fixed field widths for the multi-queue ring buffer.
`default_nettype none
package mqrb_pkg;

  localparam int ACT_W   = 3;
  localparam int STAT_W  = 3;
  localparam int ID_W    = 4;
  localparam int COUNT_W = 5;
  localparam int BYTE_W  = 20;

  localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DESTROY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;
  localparam logic [STAT_W-1:0] ST_NULL_PKT  = 3'd5;

endpackage
`default_nettype wire

FILE: sv/mqrb_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module mqrb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/multi_queue_packet_ring_buffer_core.sv
// An accepted request passes S_DESC, then S_SLOT if a pop or peek finds an entry, then S_DONE.
// Only one request is in flight; a new one is taken only when the sequencer is back in S_IDLE.
// The steps follow the descriptor RAM read and, for pop and peek, the slot RAM read after it.
// A finished result sits in the output register, so the next request can enter while it waits.
// Reset: synchronous, active high; every queue is free and no clearing pass is needed.
`default_nettype none
`include "multi_queue_packet_ring_buffer_core_macros.svh"
module multi_queue_packet_ring_buffer_core #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 32,
  parameter int SIZE_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [mqrb_pkg::ACT_W-1:0]      action,
  input  wire logic [mqrb_pkg::ID_W-1:0]       queue_id,
  input  wire logic [HANDLE_BITS-1:0]          packet_handle,
  input  wire logic [SIZE_BITS-1:0]            packet_size,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [mqrb_pkg::STAT_W-1:0]     status,
  output      logic [mqrb_pkg::ID_W-1:0]       new_queue_id,
  output      logic [HANDLE_BITS-1:0]          head_handle,
  output      logic [SIZE_BITS-1:0]            head_size,
  output      logic [mqrb_pkg::COUNT_W-1:0]    entry_count,
  output      logic [mqrb_pkg::BYTE_W-1:0]     bytes_queued
);

  // Derived widths. Each queue owns a descriptor (read pointer, write pointer,
  // fill count, byte total) in the descriptor RAM and QUEUE_DEPTH consecutive
  // entries in the slot RAM.
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTE_W  = mqrb_pkg::BYTE_W;
  localparam int DESC_W  = 2 * PTR_W + CNT_W + BYTE_W;
  localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SA_W    = $clog2(SLOTS);
  localparam int SLOT_W  = HANDLE_BITS + SIZE_BITS;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DESC = 2'd1;
  localparam logic [1:0] S_SLOT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  // Allocation bitmap lives in flip-flops so that create can find the
  // lowest free queue without touching a RAM.
  logic [NUM_QUEUES-1:0] in_use, in_use_next;

  // Captured request.
  logic [mqrb_pkg::ACT_W-1:0] req_action;
  logic [QW-1:0]              req_q;
  logic                       req_id_ok;
  logic [HANDLE_BITS-1:0]     req_handle;
  logic [SIZE_BITS-1:0]       req_size;
  logic [QW-1:0]              req_free;
  logic                       req_free_found;

  // Result being assembled before it moves to the output register.
  logic [mqrb_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [mqrb_pkg::ID_W-1:0]   res_new_id, res_new_id_next;
  logic [HANDLE_BITS-1:0]      res_handle, res_handle_next;
  logic [SIZE_BITS-1:0]        res_size, res_size_next;
  logic [CNT_W-1:0]            res_cnt, res_cnt_next;
  logic [BYTE_W-1:0]           res_bytes, res_bytes_next;
  logic                        out_load;

  // Request decode at the input.
  logic          accept;
  logic          id_in_range;
  logic [QW-1:0] q_in;
  logic          free_found;
  logic [QW-1:0] free_idx;

  // RAM ports.
  logic              desc_we;
  logic [QW-1:0]     desc_wa;
  logic [DESC_W-1:0] desc_wd;
  logic [DESC_W-1:0] desc_rd;
  logic              slot_we;
  logic [SA_W-1:0]   slot_wa;
  logic              slot_re;
  logic [SA_W-1:0]   slot_ra;
  logic [SLOT_W-1:0] slot_rd;

  // Fields of the descriptor and the slot entry just read.
  logic [PTR_W-1:0]  d_rp, d_wp;
  logic [CNT_W-1:0]  d_cnt;
  logic [BYTE_W-1:0] d_bytes;
  logic [HANDLE_BITS-1:0] s_handle;
  logic [SIZE_BITS-1:0]   s_size;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [SA_W-1:0] slot_addr(input logic [QW-1:0] q,
                                                input logic [PTR_W-1:0] p);
    return SA_W'(q) * SA_W'(QUEUE_DEPTH) + SA_W'(p);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Queue ids are 1-based on the interface.
  assign id_in_range = (queue_id != '0) && (int'(queue_id) <= NUM_QUEUES);
  assign q_in        = QW'(queue_id - 4'd1);

  // Lowest-numbered free queue.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  assign {d_rp, d_wp, d_cnt, d_bytes} = desc_rd;
  assign {s_handle, s_size}           = slot_rd;

  // The descriptor read is issued on the accepting edge; its data is there
  // in S_DESC. Only one request is in flight, so every write has landed
  // before the next read and no forwarding path is needed.
  mqrb_ram #(
    .WIDTH (DESC_W),
    .DEPTH (NUM_QUEUES),
    .ADDR_W(QW)
  ) u_desc_ram (
    .clk    (clk),
    .wr_en  (desc_we),
    .wr_addr(desc_wa),
    .wr_data(desc_wd),
    .rd_en  (accept),
    .rd_addr(q_in),
    .rd_data(desc_rd)
  );

  mqrb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .ADDR_W(SA_W)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (slot_we),
    .wr_addr(slot_wa),
    .wr_data({req_handle, req_size}),
    .rd_en  (slot_re),
    .rd_addr(slot_ra),
    .rd_data(slot_rd)
  );

  // Main sequencer: the descriptor is checked and updated in S_DESC; a pop or peek
  // of a non-empty queue goes on to S_SLOT to pick up the head entry, and a pop
  // updates its descriptor there; the result goes to the output register in S_DONE.
  always_comb begin
    state_next      = state;
    in_use_next     = in_use;
    res_status_next = res_status;
    res_new_id_next = res_new_id;
    res_handle_next = res_handle;
    res_size_next   = res_size;
    res_cnt_next    = res_cnt;
    res_bytes_next  = res_bytes;
    desc_we         = 1'b0;
    desc_wa         = req_q;
    desc_wd         = '0;
    slot_we         = 1'b0;
    slot_wa         = slot_addr(req_q, d_wp);
    slot_re         = 1'b0;
    slot_ra         = slot_addr(req_q, d_rp);
    out_load        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DESC;
        end
      end

      S_DESC: begin
        state_next      = S_DONE;
        res_status_next = mqrb_pkg::ST_OK;
        res_new_id_next = '0;
        res_handle_next = '0;
        res_size_next   = '0;
        // A queue that is in use reports its current totals unless the
        // action changes them below.
        res_cnt_next    = req_id_ok ? d_cnt : '0;
        res_bytes_next  = req_id_ok ? d_bytes : '0;

        case (req_action)
          mqrb_pkg::ACT_CREATE: begin
            res_cnt_next   = '0;
            res_bytes_next = '0;
            if (req_free_found) begin
              in_use_next[req_free] = 1'b1;
              desc_we         = 1'b1;
              desc_wa         = req_free;
              desc_wd         = '0;
              res_new_id_next = mqrb_pkg::ID_W'(req_free) + 4'd1;
            end else begin
              res_status_next = mqrb_pkg::ST_NO_FREE;
            end
          end

          mqrb_pkg::ACT_DESTROY: begin
            res_cnt_next   = '0;
            res_bytes_next = '0;
            if (!req_id_ok) begin
              res_status_next = mqrb_pkg::ST_BAD_ID;
            end else begin
              in_use_next[req_q] = 1'b0;
            end
          end

          mqrb_pkg::ACT_FLUSH: begin
            if (!req_id_ok) begin
              res_status_next = mqrb_pkg::ST_BAD_ID;
            end else begin
              desc_we        = 1'b1;
              desc_wd        = '0;
              res_cnt_next   = '0;
              res_bytes_next = '0;
            end
          end

          mqrb_pkg::ACT_PUSH: begin
            if (req_handle == '0) begin
              res_status_next = mqrb_pkg::ST_NULL_PKT;
            end else if (!req_id_ok) begin
              res_status_next = mqrb_pkg::ST_BAD_ID;
            end else if (d_cnt == CNT_W'(QUEUE_DEPTH)) begin
              res_status_next = mqrb_pkg::ST_OVERFLOW;
            end else begin
              slot_we        = 1'b1;
              desc_we        = 1'b1;
              res_cnt_next   = d_cnt + 1'b1;
              res_bytes_next = d_bytes + BYTE_W'(req_size);
              desc_wd        = {d_rp, ptr_inc(d_wp), d_cnt + 1'b1,
                                d_bytes + BYTE_W'(req_size)};
            end
          end

          mqrb_pkg::ACT_POP, mqrb_pkg::ACT_PEEK: begin
            if (!req_id_ok) begin
              res_status_next = mqrb_pkg::ST_BAD_ID;
            end else if (d_cnt == '0) begin
              res_status_next = mqrb_pkg::ST_UNDERFLOW;
            end else begin
              slot_re    = 1'b1;
              state_next = S_SLOT;
            end
          end

          default: begin
            // Unused action codes leave everything alone and report zeros.
            res_cnt_next   = '0;
            res_bytes_next = '0;
          end
        endcase
      end

      S_SLOT: begin
        state_next      = S_DONE;
        res_handle_next = s_handle;
        res_size_next   = s_size;
        if (req_action == mqrb_pkg::ACT_POP) begin
          desc_we        = 1'b1;
          res_cnt_next   = d_cnt - 1'b1;
          res_bytes_next = (s_handle != '0) ? d_bytes - BYTE_W'(s_size) : d_bytes;
          desc_wd        = {ptr_inc(d_rp), d_wp, d_cnt - 1'b1,
                            (s_handle != '0) ? d_bytes - BYTE_W'(s_size) : d_bytes};
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
    end
  end

  // Request capture; the bitmap is sampled here and cannot change before
  // the request itself updates it in S_DESC.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action     <= action;
      req_q          <= q_in;
      req_id_ok      <= id_in_range && in_use[q_in];
      req_handle     <= packet_handle;
      req_size       <= packet_size;
      req_free       <= free_idx;
      req_free_found <= free_found;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_new_id <= res_new_id_next;
    res_handle <= res_handle_next;
    res_size   <= res_size_next;
    res_cnt    <= res_cnt_next;
    res_bytes  <= res_bytes_next;
  end

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      new_queue_id <= res_new_id;
      head_handle  <= res_handle;
      head_size    <= res_size;
      entry_count  <= mqrb_pkg::COUNT_W'(res_cnt);
      bytes_queued <= res_bytes;
    end
  end

  // An accepted request always starts with the descriptor lookup.
  `MQRB_ASSERT_NXT(a_accept_to_desc, clk, rst, in_valid && !in_stall, state == S_DESC)
  // A failed request never hands out a queue id or a packet.
  `MQRB_ASSERT_IMP(a_fail_no_data, clk, rst, out_valid && (status != mqrb_pkg::ST_OK), (head_handle == '0) && (new_queue_id == '0))
  // A reported fill level never exceeds the queue depth.
  `MQRB_ASSERT_IMP(a_count_bound, clk, rst, out_valid, int'(entry_count) <= QUEUE_DEPTH)

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the multi-queue packet ring buffer core.
`default_nettype none
module tb_top;

  localparam int ACT_W    = mqrb_pkg::ACT_W;
  localparam int STAT_W   = mqrb_pkg::STAT_W;
  localparam int ID_W     = mqrb_pkg::ID_W;
  localparam int COUNT_W  = mqrb_pkg::COUNT_W;
  localparam int BYTE_W   = mqrb_pkg::BYTE_W;
  localparam int NQ       = 8;
  localparam int DEPTH    = 16;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int N_ITEMS  = 1650;
  localparam int IDLE_LIMIT = 5000;

  // The two action codes that the block must ignore.
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [ID_W-1:0]     qid;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic                hold;
  } ring_op_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     new_id;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [COUNT_W-1:0]  count;
    logic [BYTE_W-1:0]   bytes;
  } ring_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action = '0;
  logic [ID_W-1:0]     queue_id = '0;
  logic [HANDLE_W-1:0] packet_handle = '0;
  logic [SIZE_W-1:0]   packet_size = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     new_queue_id;
  logic [HANDLE_W-1:0] head_handle;
  logic [SIZE_W-1:0]   head_size;
  logic [COUNT_W-1:0]  entry_count;
  logic [BYTE_W-1:0]   bytes_queued;

  // Two copies of the ring state: copy 0 shadows the stimulus as it is built, so that
  // sequences can aim at live queues; copy 1 tracks the block request by request.
  logic                q_live  [2][NQ];
  logic [PTR_W-1:0]    q_rd    [2][NQ];
  logic [PTR_W-1:0]    q_wr    [2][NQ];
  logic [COUNT_W-1:0]  q_fill  [2][NQ];
  logic [BYTE_W-1:0]   q_bytes [2][NQ];
  logic [HANDLE_W-1:0] slot_h  [2][NQ*DEPTH];
  logic [SIZE_W-1:0]   slot_s  [2][NQ*DEPTH];

  ring_op_t    queued_ops[$];
  ring_reply_t owed_replies[$];
  ring_op_t    cur_op;
  int          n_total = 0;
  int          n_sent = 0;
  int          n_replies = 0;
  int          n_fail = 0;

  multi_queue_packet_ring_buffer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .queue_id      (queue_id),
    .packet_handle (packet_handle),
    .packet_size   (packet_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .new_queue_id  (new_queue_id),
    .head_handle   (head_handle),
    .head_size     (head_size),
    .entry_count   (entry_count),
    .bytes_queued  (bytes_queued)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Empties one queue: both pointers, the entry count and the byte total go back to zero.
  function automatic void empty_queue(input int m, input int q);
    q_rd[m][q]    = '0;
    q_wr[m][q]    = '0;
    q_fill[m][q]  = '0;
    q_bytes[m][q] = '0;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // Applies one request to state copy m and returns the reply that it gives.
  function automatic ring_reply_t apply_ring_op(input int m, input ring_op_t op);
    ring_reply_t r;
    logic        id_ok;
    logic        live;
    int          q;
    int          slot;
    r     = '0;
    id_ok = (op.qid >= 1) && (op.qid <= NQ);
    q     = id_ok ? int'(op.qid) - 1 : 0;
    id_ok = id_ok && q_live[m][q];
    live  = id_ok;
    case (op.act)
      mqrb_pkg::ACT_CREATE: begin
        live     = 1'b0;
        r.status = mqrb_pkg::ST_NO_FREE;
        for (int i = 0; i < NQ; i++) begin
          if (!live && !q_live[m][i]) begin
            empty_queue(m, i);
            q_live[m][i] = 1'b1;
            r.new_id     = ID_W'(i + 1);
            r.status     = mqrb_pkg::ST_OK;
            q            = i;
            live         = 1'b1;
          end
        end
      end
      mqrb_pkg::ACT_DESTROY, mqrb_pkg::ACT_FLUSH: begin
        if (!id_ok) begin
          r.status = mqrb_pkg::ST_BAD_ID;
        end else begin
          empty_queue(m, q);
          if (op.act == mqrb_pkg::ACT_DESTROY) begin
            q_live[m][q] = 1'b0;
            live         = 1'b0;
          end
        end
      end
      mqrb_pkg::ACT_PUSH: begin
        // The null check takes priority over the id check.
        if (op.handle == '0) begin
          r.status = mqrb_pkg::ST_NULL_PKT;
        end else if (!id_ok) begin
          r.status = mqrb_pkg::ST_BAD_ID;
        end else if (q_fill[m][q] >= DEPTH) begin
          r.status = mqrb_pkg::ST_OVERFLOW;
        end else begin
          slot            = q * DEPTH + int'(q_wr[m][q]);
          slot_h[m][slot] = op.handle;
          slot_s[m][slot] = op.size;
          q_wr[m][q]      = advance(q_wr[m][q]);
          q_fill[m][q]    = q_fill[m][q] + 1'b1;
          q_bytes[m][q]   = q_bytes[m][q] + BYTE_W'(op.size);
        end
      end
      mqrb_pkg::ACT_POP, mqrb_pkg::ACT_PEEK: begin
        if (!id_ok) begin
          r.status = mqrb_pkg::ST_BAD_ID;
        end else if (q_fill[m][q] == '0) begin
          r.status = mqrb_pkg::ST_UNDERFLOW;
        end else begin
          slot     = q * DEPTH + int'(q_rd[m][q]);
          r.handle = slot_h[m][slot];
          r.size   = slot_s[m][slot];
          if (op.act == mqrb_pkg::ACT_POP) begin
            q_rd[m][q]   = advance(q_rd[m][q]);
            q_fill[m][q] = q_fill[m][q] - 1'b1;
            if (r.handle != '0) q_bytes[m][q] = q_bytes[m][q] - BYTE_W'(r.size);
          end
        end
      end
      default: begin
        live = 1'b0;
      end
    endcase
    if (live) begin
      r.count = q_fill[m][q];
      r.bytes = q_bytes[m][q];
    end
    return r;
  endfunction

  // Appends a request to the stimulus and plays it on the shadow copy. Every 400th
  // request makes the sender wait until all replies owed so far have arrived.
  task automatic add_op(input logic [ACT_W-1:0] act, input int qid,
                        input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] s);
    ring_op_t    op;
    ring_reply_t ignored;
    op.act    = act;
    op.qid    = ID_W'(qid);
    op.handle = h;
    op.size   = s;
    op.hold   = (queued_ops.size() % 400 == 399);
    ignored   = apply_ring_op(0, op);
    queued_ops.push_back(op);
  endtask

  function automatic logic [HANDLE_W-1:0] rand_handle();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2:       return HANDLE_W'(1);
      default: return HANDLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(15));
      default: return SIZE_W'($urandom());
    endcase
  endfunction

  // Returns the id of a queue that is in use in the shadow copy, or 0 if there is none.
  function automatic int pick_live();
    int ids[$];
    for (int i = 0; i < NQ; i++) begin
      if (q_live[0][i]) ids.push_back(i + 1);
    end
    if (ids.size() == 0) return 0;
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  // The run moves through three thirds: a slow receiver, then a slow sender, then
  // neither side holding back.
  function automatic int sender_idle_pct();
    if (n_sent < n_total / 3) return 7;
    if (n_sent < 2 * n_total / 3) return 86;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (n_sent < n_total / 3) return 86;
    if (n_sent < 2 * n_total / 3) return 7;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_fail++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("reply %0d %s got 0x%0h want 0x%0h",
                                n_replies, name, got, want));
    end
  endtask

  // Driver: presents requests from the stimulus queue. A request that has been taken
  // is predicted at once, so the owed replies stay in the order of acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_replies.push_back(apply_ring_op(1, cur_op));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_ops.size() > 0 && (!queued_ops[0].hold || owed_replies.size() == 0) &&
            $urandom_range(99) >= sender_idle_pct()) begin
          cur_op = queued_ops.pop_front();
          in_valid      <= 1'b1;
          action        <= cur_op.act;
          queue_id      <= cur_op.qid;
          packet_handle <= cur_op.handle;
          packet_size   <= cur_op.size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted reply against the oldest one owed, then draws the
  // stall for the next cycle.
  always @(posedge clk) begin : monitor
    ring_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          report_mismatch($sformatf("reply with nothing owed, status %0d", status));
        end else begin
          want = owed_replies.pop_front();
          n_replies++;
          compare_field("status", 32'(status), 32'(want.status));
          compare_field("new_queue_id", 32'(new_queue_id), 32'(want.new_id));
          compare_field("head_handle", 32'(head_handle), 32'(want.handle));
          compare_field("head_size", 32'(head_size), 32'(want.size));
          compare_field("entry_count", 32'(entry_count), 32'(want.count));
          compare_field("bytes_queued", 32'(bytes_queued), 32'(want.bytes));
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct());
    end
  end

  // Watchdog: ends the run once too many cycles pass with neither channel moving.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int qid;
    int n;
    for (int m = 0; m < 2; m++) begin
      for (int q = 0; q < NQ; q++) begin
        q_live[m][q] = 1'b0;
        empty_queue(m, q);
      end
      for (int s = 0; s < NQ * DEPTH; s++) begin
        slot_h[m][s] = '0;
        slot_s[m][s] = '0;
      end
    end

    // Directed part. Before any create every queue is free: a null push must report
    // the null handle rather than the bad id, and reads of free or zero ids are refused.
    add_op(mqrb_pkg::ACT_PUSH, 1, '0, 16'h1234);
    add_op(mqrb_pkg::ACT_PEEK, 1, '0, '0);
    add_op(mqrb_pkg::ACT_POP, 0, '0, '0);
    // Claim the whole pool, then one create too many.
    repeat (NQ + 1) add_op(mqrb_pkg::ACT_CREATE, 0, '0, '0);
    add_op(mqrb_pkg::ACT_PUSH, 3, '1, '1);
    add_op(mqrb_pkg::ACT_PUSH, 3, HANDLE_W'(1), '0);
    add_op(mqrb_pkg::ACT_PEEK, 3, '0, '0);
    // Two pops empty the queue and the third underflows.
    repeat (3) add_op(mqrb_pkg::ACT_POP, 3, '0, '0);
    add_op(ACT_SPARE_6, 15, '1, '1);
    add_op(ACT_SPARE_7, 4, rand_handle(), rand_size());
    add_op(mqrb_pkg::ACT_FLUSH, 15, '0, '0);
    add_op(mqrb_pkg::ACT_DESTROY, 9, '0, '0);
    add_op(mqrb_pkg::ACT_DESTROY, 2, '0, '0);
    add_op(mqrb_pkg::ACT_FLUSH, 3, '0, '0);

    // Random part, made mostly of runs aimed at live queues: fills that run into
    // overflow, drains that run into underflow, queue turnover and some noise.
    while (queued_ops.size() < N_ITEMS) begin
      qid = pick_live();
      n   = $urandom_range(1, 20);
      case ($urandom_range(9))
        0, 1, 2: begin
          if (qid == 0) begin
            add_op(mqrb_pkg::ACT_CREATE, $urandom_range(15), rand_handle(), rand_size());
          end else begin
            repeat (n) add_op(mqrb_pkg::ACT_PUSH, qid, rand_handle(), rand_size());
          end
        end
        3, 4, 5: begin
          if (qid == 0) begin
            add_op(mqrb_pkg::ACT_CREATE, $urandom_range(15), rand_handle(), rand_size());
          end else begin
            repeat (n) begin
              add_op($urandom_range(3) == 0 ? mqrb_pkg::ACT_PEEK : mqrb_pkg::ACT_POP, qid,
                     rand_handle(), rand_size());
            end
          end
        end
        6: begin
          if (qid != 0) begin
            add_op($urandom_range(1) ? mqrb_pkg::ACT_DESTROY : mqrb_pkg::ACT_FLUSH, qid,
                   '0, '0);
          end
          add_op(mqrb_pkg::ACT_CREATE, 0, '0, '0);
        end
        7: begin
          add_op(mqrb_pkg::ACT_CREATE, $urandom_range(15), rand_handle(), rand_size());
        end
        8: begin
          repeat (10) begin
            qid = pick_live();
            add_op($urandom_range(1) ? mqrb_pkg::ACT_PUSH : mqrb_pkg::ACT_POP, qid,
                   rand_handle(), rand_size());
          end
        end
        default: begin
          add_op(ACT_W'($urandom_range(7)), $urandom_range(15), rand_handle(), rand_size());
        end
      endcase
    end
    n_total = queued_ops.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < n_total || owed_replies.size() != 0) @(posedge clk);
    // Allow a stray late reply to show up before the verdict.
    repeat (12) @(posedge clk);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: multi_queue_packet_ring_buffer_core.f
+incdir+sv
sv/mqrb_pkg.sv
sv/mqrb_ram.sv
sv/multi_queue_packet_ring_buffer_core.sv
test/tb_top.sv
